FILE: hdl/frtp_pkg.sv
// shared types, codes and constants of the ftp reply / telnet parser
package frtp_pkg;

  localparam logic [7:0] TN_IAC  = 8'd255;
  localparam logic [7:0] TN_DONT = 8'd254;
  localparam logic [7:0] TN_DO   = 8'd253;
  localparam logic [7:0] TN_WONT = 8'd252;
  localparam logic [7:0] TN_WILL = 8'd251;
  localparam logic [7:0] CH_CR   = 8'd13;
  localparam logic [7:0] CH_LF   = 8'd10;
  localparam logic [7:0] CH_SP   = 8'd32;
  localparam logic [7:0] CH_DASH = 8'd45;
  localparam logic [7:0] CH_ZERO = 8'd48;
  localparam logic [7:0] CH_NINE = 8'd57;

  localparam logic [9:0] TIMEOUT_CODE  = 10'd421;
  localparam logic [9:0] MAX_LINE_RST  = 10'd512;
  localparam int         MIN_LINE      = 5;
  localparam int         PAT_LEN       = 29;
  localparam int         QDEPTH        = 4;

  // telnet parser phases
  localparam logic [1:0] PH_DATA = 2'd0;
  localparam logic [1:0] PH_IAC  = 2'd1;
  localparam logic [1:0] PH_OPT  = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_TX   = 2'd0;
  localparam logic [1:0] KIND_TEXT = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  // reply status
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOCODE  = 2'd1;
  localparam logic [1:0] ST_TIMEOUT = 2'd2;
  localparam logic [1:0] ST_LOST    = 2'd3;

  // queue entry kinds
  localparam logic OP_REPLY  = 1'b0;
  localparam logic OP_REFUSE = 1'b1;

  // configuration register indexes
  localparam logic REG_VMS      = 1'b0;
  localparam logic REG_MAX_LINE = 1'b1;

  typedef struct packed {
    logic       op;
    logic       has_text;
    logic       has_done;
    logic       dont;
    logic [7:0] byte_val;
    logic [9:0] code;
    logic [3:0] cls;
    logic [1:0] status;
  } entry_t;

  function automatic logic [7:0] pat_char(input logic [4:0] i);
    logic [7:0] c;
    unique case (i)
      5'd0:  c = "5";
      5'd1:  c = "0";
      5'd2:  c = "0";
      5'd3:  c = " ";
      5'd4:  c = "F";
      5'd5:  c = "T";
      5'd6:  c = "P";
      5'd7:  c = " ";
      5'd8:  c = "c";
      5'd9:  c = "o";
      5'd10: c = "n";
      5'd11: c = "n";
      5'd12: c = "e";
      5'd13: c = "c";
      5'd14: c = "t";
      5'd15: c = "i";
      5'd16: c = "o";
      5'd17: c = "n";
      5'd18: c = " ";
      5'd19: c = "t";
      5'd20: c = "e";
      5'd21: c = "r";
      5'd22: c = "m";
      5'd23: c = "i";
      5'd24: c = "n";
      5'd25: c = "a";
      5'd26: c = "t";
      5'd27: c = "e";
      5'd28: c = "d";
      default: c = 8'd0;
    endcase
    return c;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

FILE: hdl/frtp_in_if.sv
// byte channel into the parser
interface frtp_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] rx_byte;

  modport source (output valid, func, rx_byte, input ready);
  modport sink (input valid, func, rx_byte, output ready);
endinterface

FILE: hdl/frtp_out_if.sv
// result channel out of the parser
interface frtp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic [9:0] reply_code;
  logic [3:0] reply_class;
  logic [1:0] status;
  logic       last;

  modport source (output valid, kind, out_byte, reply_code, reply_class, status, last,
                  input ready);
  modport sink (input valid, kind, out_byte, reply_code, reply_class, status, last,
                output ready);
endinterface

FILE: hdl/frtp_front.sv
// front end: telnet refusal and reply line parsing, one byte per cycle while accept is high
module frtp_front #(
  parameter int MAX_LINE = 512
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic                func,
  input  logic [7:0]          rx_byte,
  input  logic                vms_server,
  input  logic [9:0]          max_line,
  output logic                push,
  output frtp_pkg::entry_t    entry
);

  localparam int IW = $clog2(MAX_LINE);
  localparam int LW = $clog2(MAX_LINE + 1);
  localparam int CW = (LW > 10) ? LW : 10;

  logic [1:0]    telnet_phase, telnet_phase_next;
  logic          refuse_with_dont, refuse_with_dont_next;
  logic [IW-1:0] line_index, line_index_next;
  logic [7:0]    line_head [4];
  logic [7:0]    line_head_next [4];
  logic          first_line, first_line_next;
  logic [9:0]    opening_code, opening_code_next;
  logic          pattern_matching, pattern_matching_next;

  logic [CW-1:0] ml_x, lim, idx_x, idx_n_x;
  logic          store, pat_hit, has_code, done, push_c;
  logic [7:0]    sep;
  logic [3:0]    d0, d1, d2;
  logic [9:0]    code;

  always_comb begin
    ml_x = CW'(max_line);
    if (ml_x < CW'(frtp_pkg::MIN_LINE)) begin
      lim = CW'(frtp_pkg::MIN_LINE);
    end else if (ml_x > CW'(MAX_LINE)) begin
      lim = CW'(MAX_LINE);
    end else begin
      lim = ml_x;
    end
  end

  always_comb begin
    telnet_phase_next     = telnet_phase;
    refuse_with_dont_next = refuse_with_dont;
    line_index_next       = line_index;
    line_head_next        = line_head;
    first_line_next       = first_line;
    opening_code_next     = opening_code;
    pattern_matching_next = pattern_matching;
    push_c   = 1'b0;
    entry    = '0;
    idx_x    = CW'(line_index);
    idx_n_x  = '0;
    store    = 1'b0;
    pat_hit  = 1'b0;
    has_code = 1'b0;
    done     = 1'b0;
    sep      = 8'd0;
    d0       = 4'd0;
    d1       = 4'd0;
    d2       = 4'd0;
    code     = 10'd0;

    if (func) begin
      telnet_phase_next     = frtp_pkg::PH_DATA;
      refuse_with_dont_next = 1'b0;
      line_index_next       = '0;
      line_head_next        = '{default: 8'd0};
      first_line_next       = 1'b1;
      opening_code_next     = 10'd0;
      pattern_matching_next = 1'b1;
      push_c          = 1'b1;
      entry.op        = frtp_pkg::OP_REPLY;
      entry.has_done  = 1'b1;
      entry.status    = frtp_pkg::ST_LOST;
    end else begin
      unique case (telnet_phase)
        frtp_pkg::PH_IAC: begin
          if (rx_byte == frtp_pkg::TN_DO || rx_byte == frtp_pkg::TN_DONT) begin
            refuse_with_dont_next = 1'b1;
            telnet_phase_next     = frtp_pkg::PH_OPT;
          end else if (rx_byte == frtp_pkg::TN_WILL || rx_byte == frtp_pkg::TN_WONT) begin
            refuse_with_dont_next = 1'b0;
            telnet_phase_next     = frtp_pkg::PH_OPT;
          end else begin
            telnet_phase_next = frtp_pkg::PH_DATA;
          end
        end
        frtp_pkg::PH_OPT: begin
          push_c            = 1'b1;
          entry.op          = frtp_pkg::OP_REFUSE;
          entry.dont        = refuse_with_dont;
          entry.byte_val    = rx_byte;
          telnet_phase_next = frtp_pkg::PH_DATA;
        end
        default: begin
          if (rx_byte == frtp_pkg::TN_IAC) begin
            telnet_phase_next = frtp_pkg::PH_IAC;
          end else begin
            telnet_phase_next = frtp_pkg::PH_DATA;
            store = (rx_byte != frtp_pkg::CH_CR) && (idx_x < lim - CW'(1));
            if (store) begin
              if (idx_x < CW'(4)) begin
                line_head_next[idx_x[1:0]] = rx_byte;
              end
              if (idx_x < CW'(frtp_pkg::PAT_LEN) &&
                  rx_byte != frtp_pkg::pat_char(idx_x[4:0])) begin
                pattern_matching_next = 1'b0;
              end
              line_index_next = line_index + IW'(1);
              push_c          = 1'b1;
              entry.has_text  = 1'b1;
              entry.byte_val  = rx_byte;
            end
            if (rx_byte == frtp_pkg::CH_LF) begin
              idx_n_x = CW'(line_index_next);
              pat_hit = pattern_matching_next && (idx_n_x >= CW'(frtp_pkg::PAT_LEN));
              sep     = line_head_next[3];
              has_code = (idx_n_x >= CW'(4)) &&
                         (sep == frtp_pkg::CH_SP || sep == frtp_pkg::CH_DASH) &&
                         frtp_pkg::is_digit(line_head_next[0]) &&
                         frtp_pkg::is_digit(line_head_next[1]) &&
                         frtp_pkg::is_digit(line_head_next[2]);
              d0 = line_head_next[0][3:0];
              d1 = line_head_next[1][3:0];
              d2 = line_head_next[2][3:0];
              if (has_code) begin
                code = 10'(d0) * 10'd100 + 10'(d1) * 10'd10 + 10'(d2);
              end
              if (first_line) begin
                if (code == 10'd0) begin
                  push_c         = 1'b1;
                  entry.has_done = 1'b1;
                  entry.status   = frtp_pkg::ST_NOCODE;
                end else if (sep == frtp_pkg::CH_DASH) begin
                  opening_code_next = code;
                  first_line_next   = 1'b0;
                end else begin
                  done = 1'b1;
                end
              end else if (code == opening_code && sep == frtp_pkg::CH_SP) begin
                done = 1'b1;
              end
              if (done) begin
                push_c         = 1'b1;
                entry.has_done = 1'b1;
                entry.code     = code;
                // a nonzero code always comes from three digits, so the class is the first
                entry.cls      = has_code ? d0 : 4'd0;
                entry.status   = (code == frtp_pkg::TIMEOUT_CODE || (vms_server && pat_hit)) ?
                                 frtp_pkg::ST_TIMEOUT : frtp_pkg::ST_OK;
                first_line_next = 1'b1;
              end
              line_index_next       = '0;
              pattern_matching_next = 1'b1;
            end
          end
        end
      endcase
    end
  end

  assign push = accept && push_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      telnet_phase     <= frtp_pkg::PH_DATA;
      refuse_with_dont <= 1'b0;
      line_index       <= '0;
      line_head        <= '{default: 8'd0};
      first_line       <= 1'b1;
      opening_code     <= 10'd0;
      pattern_matching <= 1'b1;
    end else if (accept) begin
      telnet_phase     <= telnet_phase_next;
      refuse_with_dont <= refuse_with_dont_next;
      line_index       <= line_index_next;
      line_head        <= line_head_next;
      first_line       <= first_line_next;
      opening_code     <= opening_code_next;
      pattern_matching <= pattern_matching_next;
    end
  end

endmodule

FILE: hdl/frtp_queue.sv
// short queue of classified entries between front and back
module frtp_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  frtp_pkg::entry_t push_entry,
  input  logic             pop,
  output logic             full,
  output logic             nonempty,
  output frtp_pkg::entry_t head
);

  localparam int PW = $clog2(frtp_pkg::QDEPTH);
  localparam int CNTW = $clog2(frtp_pkg::QDEPTH + 1);

  frtp_pkg::entry_t mem [frtp_pkg::QDEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [CNTW-1:0]  count;
  logic             do_push, do_pop;

  assign full     = (count == CNTW'(frtp_pkg::QDEPTH));
  assign nonempty = (count != '0);
  assign head     = mem[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CNTW'(1);
        2'b01:   count <= count - CNTW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hdl/frtp_back.sv
// back end: expands queue entries into result beats through an output register
module frtp_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              nonempty,
  input  frtp_pkg::entry_t  head,
  output logic              pop,
  frtp_out_if.source        res
);

  logic [1:0] sub;
  logic [1:0] n_res;
  logic       load, final_beat;
  logic       out_valid;
  logic [1:0] kind_c, status_c;
  logic [7:0] byte_c;
  logic [9:0] code_c;
  logic [3:0] cls_c;

  always_comb begin
    kind_c   = frtp_pkg::KIND_DONE;
    byte_c   = 8'd0;
    code_c   = 10'd0;
    cls_c    = 4'd0;
    status_c = frtp_pkg::ST_OK;
    if (head.op == frtp_pkg::OP_REFUSE) begin
      n_res  = 2'd3;
      kind_c = frtp_pkg::KIND_TX;
      case (sub)
        2'd0:    byte_c = frtp_pkg::TN_IAC;
        2'd1:    byte_c = head.dont ? frtp_pkg::TN_DONT : frtp_pkg::TN_WONT;
        default: byte_c = head.byte_val;
      endcase
    end else begin
      n_res = 2'(head.has_text) + 2'(head.has_done);
      if (head.has_text && sub == 2'd0) begin
        kind_c = frtp_pkg::KIND_TEXT;
        byte_c = head.byte_val;
      end else begin
        code_c   = head.code;
        cls_c    = head.cls;
        status_c = head.status;
      end
    end
  end

  assign final_beat = (sub == n_res - 2'd1);
  assign load       = nonempty && (!out_valid || res.ready);
  assign pop        = load && final_beat;
  assign res.valid  = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sub       <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        sub       <= final_beat ? 2'd0 : sub + 2'd1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res.kind        <= kind_c;
      res.out_byte    <= byte_c;
      res.reply_code  <= code_c;
      res.reply_class <= cls_c;
      res.status      <= status_c;
      res.last        <= final_beat;
    end
  end

endmodule

FILE: hdl/ftp_reply_telnet_parser.sv
// top level of the ftp control reply parser with telnet option refusal
//
// byte_ch carries one control-connection byte per beat (func 0), or a
// connection-lost event (func 1). result_ch carries result beats: bytes to
// transmit back (telnet refusals), stored reply text, and reply-finished
// beats with code, class and status; last marks the final beat of a byte.
// The apb port holds vms_server at address 0 and max_line at address 4.
//
// The front parser takes one byte per cycle while the queue is not full and
// writes classified entries into a four-entry queue; the back end turns each
// entry into one to three result beats, one per cycle while result_ch is
// ready, through an output register; a result passes through the queue and
// the output register. Sustained rate is one byte per cycle when each byte
// yields at most one beat and result_ch stays ready; a telnet refusal yields three beats.
// byte_ch.ready drops only when the queue is full, so a stalled receiver
// holds its beat and backs up into the queue, then into the source.
// Reset (rst, synchronous) empties the queue, clears the parse state and
// sets vms_server to 0 and max_line to 512.
module ftp_reply_telnet_parser #(
  parameter int MAX_LINE = 512
) (
  input  logic        clk,
  input  logic        rst,
  frtp_in_if.sink     byte_ch,
  frtp_out_if.source  result_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic             vms_server;
  logic [9:0]       max_line;
  logic             accept, push, pop, full, nonempty, cfg_wr;
  frtp_pkg::entry_t push_entry, head;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == frtp_pkg::REG_MAX_LINE) ? 32'(max_line) : 32'(vms_server);

  always_ff @(posedge clk) begin
    if (rst) begin
      vms_server <= 1'b0;
      max_line   <= frtp_pkg::MAX_LINE_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == frtp_pkg::REG_VMS) begin
        vms_server <= pwdata[0];
      end else begin
        max_line <= pwdata[9:0];
      end
    end
  end

  assign byte_ch.ready = !full;
  assign accept        = byte_ch.valid && byte_ch.ready;

  frtp_front #(.MAX_LINE(MAX_LINE)) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .func       (byte_ch.func),
    .rx_byte    (byte_ch.rx_byte),
    .vms_server (vms_server),
    .max_line   (max_line),
    .push       (push),
    .entry      (push_entry)
  );

  frtp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (full),
    .nonempty   (nonempty),
    .head       (head)
  );

  frtp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .nonempty (nonempty),
    .head     (head),
    .pop      (pop),
    .res      (result_ch)
  );

endmodule

FILE: hdl/frtp_checker.sv
// port-level checks on the result channel, bound to the top level
module frtp_checker (
  input logic       clk,
  input logic       rst,
  input logic       valid,
  input logic       ready,
  input logic [1:0] kind,
  input logic [7:0] out_byte,
  input logic [9:0] reply_code,
  input logic [3:0] reply_class,
  input logic [1:0] status,
  input logic       last
);

  // no beat right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !valid)
    else $error("result beat valid right after reset");

  // a finished reply always closes the results of its byte
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    valid && kind == frtp_pkg::KIND_DONE |-> last)
    else $error("reply-finished beat not marked last");

  // byte beats carry no code, class or status
  a_byte_clean: assert property (@(posedge clk) disable iff (rst)
    valid && kind != frtp_pkg::KIND_DONE |->
      reply_code == 10'd0 && reply_class == 4'd0 && status == frtp_pkg::ST_OK)
    else $error("byte beat with reply fields set");

  // a stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable(kind) && $stable(out_byte) &&
      $stable(reply_code) && $stable(status) && $stable(last))
    else $error("stalled result beat changed");

endmodule

bind ftp_reply_telnet_parser frtp_checker u_frtp_checker (
  .clk         (clk),
  .rst         (rst),
  .valid       (result_ch.valid),
  .ready       (result_ch.ready),
  .kind        (result_ch.kind),
  .out_byte    (result_ch.out_byte),
  .reply_code  (result_ch.reply_code),
  .reply_class (result_ch.reply_class),
  .status      (result_ch.status),
  .last        (result_ch.last)
);
